/* design/uxd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder package
// Shared types, character codes, phase codes and the hex digit decode used by
// the escape decoder modules.
// ----------------------------------------------------------------------------
package uxd_pkg;

    // Byte width of one record byte.
    localparam int BYTE_W = 8;

    // Decode phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BSL   = 2'd1;
    localparam logic [1:0] PH_HEX   = 2'd2;
    localparam logic [1:0] PH_CARET = 2'd3;

    // Escape lead characters and the control-character offset.
    localparam logic [7:0] CH_BSL     = 8'h5C;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CARET_MASK = 8'h40;

    // Value returned by hex_value for a byte that is not a hex digit.
    localparam logic [4:0] HEX_NONE = 5'd16;

    // One byte of a record with its end-of-record mark.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    // Returns 0 to 15 for a hex digit and HEX_NONE for anything else.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                d = b - 8'h30;
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                d = b - 8'h57;
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                d = b - 8'h37;
            end
            else
            begin
                d = {3'b000, HEX_NONE};
            end
            return d[4:0];
        end
    endfunction

endpackage

/* design/uxd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder input register
// Holds one accepted request until the decode stage can take it.
// ----------------------------------------------------------------------------
module uxd_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  uxd_pkg::item_t  req_item,
    input  logic            advance,
    output logic            held_valid,
    output uxd_pkg::item_t  held_item
);

    logic           valid_reg;
    logic           valid_next;
    uxd_pkg::item_t item_reg;
    logic           take;

    // The register frees up whenever the decode stage moves on.
    assign req_ready = !valid_reg || advance;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= req_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

/* design/uxd_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder core
// Per-byte escape state machine: decides whether a byte yields a result and
// what that result is, and keeps the pending escape state.
// ----------------------------------------------------------------------------
module uxd_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  uxd_pkg::item_t  cur_item,
    output logic            emit,
    output uxd_pkg::item_t  res_item
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;
    logic [4:0] hex_val;
    logic [7:0] b;
    logic       last;

    assign b       = cur_item.data;
    assign last    = cur_item.last;
    assign hex_val = uxd_pkg::hex_value(b);

    // Next phase and the result for the current byte.
    always_comb
    begin
        phase_next    = phase_reg;
        nibble_next   = nibble_reg;
        emit          = 1'b0;
        res_item.data = b;
        res_item.last = last;
        unique case (phase_reg)
            uxd_pkg::PH_IDLE:
            begin
                if ((b == uxd_pkg::CH_BSL || b == uxd_pkg::CH_CARET) && !last)
                begin
                    phase_next = (b == uxd_pkg::CH_BSL) ? uxd_pkg::PH_BSL
                                                        : uxd_pkg::PH_CARET;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            uxd_pkg::PH_BSL:
            begin
                phase_next = uxd_pkg::PH_IDLE;
                if (hex_val[4])
                begin
                    emit = 1'b1;
                end
                else if (last)
                begin
                    // Escape cut short: give back the backslash.
                    emit          = 1'b1;
                    res_item.data = uxd_pkg::CH_BSL;
                    res_item.last = 1'b1;
                end
                else
                begin
                    nibble_next = hex_val[3:0];
                    phase_next  = uxd_pkg::PH_HEX;
                end
            end
            uxd_pkg::PH_HEX:
            begin
                // A non-hex low digit counts as 16 and so sets bit 4.
                emit          = 1'b1;
                res_item.data = {nibble_reg, 4'b0000} | {3'b000, hex_val};
                nibble_next   = 4'h0;
                phase_next    = uxd_pkg::PH_IDLE;
            end
            uxd_pkg::PH_CARET:
            begin
                emit          = 1'b1;
                res_item.data = uxd_pkg::CARET_MASK ^ b;
                phase_next    = uxd_pkg::PH_IDLE;
            end
        endcase
    end

    // Escape state advances only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uxd_pkg::PH_IDLE;
            nibble_reg <= 4'h0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
        end
    end

    // A consumed last byte always ends the record.
    a_last_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (phase_reg == uxd_pkg::PH_IDLE))
        else $error("escape state pending after end of record");

    // The second hex digit always completes a result.
    a_hex_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == uxd_pkg::PH_HEX) |-> emit)
        else $error("hex escape completed without a result");

    // A pending nibble exists only while waiting for the low digit.
    a_nibble_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != uxd_pkg::PH_HEX) |-> (nibble_reg == 4'h0))
        else $error("stale high nibble outside hex phase");

    // Idle non-lead bytes pass straight through.
    a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == uxd_pkg::PH_IDLE && b != uxd_pkg::CH_BSL &&
         b != uxd_pkg::CH_CARET) |-> (emit && res_item.data == b))
        else $error("plain byte not passed through");

endmodule

/* design/uxd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder result register
// Holds one decoded byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module uxd_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_valid,
    input  logic            emit,
    input  uxd_pkg::item_t  res_item,
    output logic            advance,
    output logic            out_valid,
    input  logic            out_ready,
    output uxd_pkg::item_t  out_item
);

    logic           valid_reg;
    logic           valid_next;
    uxd_pkg::item_t item_reg;
    logic           load;

    // The decode stage may move on when this register is empty or drains.
    assign advance = !valid_reg || out_ready;
    assign load    = advance && src_valid && emit;

    always_comb
    begin
        if (advance)
        begin
            valid_next = src_valid && emit;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/unix_escape_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder top level
// Turns backslash, backslash-hex and caret escapes of a byte record back into
// plain bytes.
//
//   Channel   Role     Payload
//   s_axis    in       tdata = in_byte[7:0], tlast = in_last
//   m_axis    out      tdata = out_byte[7:0], tlast = out_last
//
// One byte is taken every clock while m_axis is not stalled; each byte yields zero or one result.
// An accepted byte is first held in the input register; its result, if any,
// enters the result register at the clock edge that moves the byte through the
// escape state machine, and is then offered on m_axis.
// Reset is asynchronous and active low and clears all valid and escape state.
// A stall on m_axis holds both registers; s_axis stays ready while the input
// register is empty or moving on.
// ----------------------------------------------------------------------------
module unix_escape_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    uxd_pkg::item_t req_item;
    uxd_pkg::item_t held_item;
    uxd_pkg::item_t res_item;
    uxd_pkg::item_t out_item;
    logic           held_valid;
    logic           advance;
    logic           emit;
    logic           step;

    assign req_item.data = s_axis_tdata;
    assign req_item.last = s_axis_tlast;

    // Input register.
    uxd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_item   (req_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // A byte is consumed when it is held and the result side can take it.
    assign step = held_valid && advance;

    uxd_decode u_dec
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_item (held_item),
        .emit     (emit),
        .res_item (res_item)
    );

    // Result register.
    uxd_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (held_valid),
        .emit      (emit),
        .res_item  (res_item),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = out_item.data;
    assign m_axis_tlast = out_item.last;

endmodule
